[src/rrt_pkg.sv]
// Shared types and codes for the response route table.
`timescale 1ns / 1ps

package rrt_pkg;

  localparam logic [1:0] REQ_RECORD     = 2'd0;
  localparam logic [1:0] REQ_ROUTE      = 2'd1;
  localparam logic [1:0] REQ_DISCONNECT = 2'd2;

  localparam logic [1:0] ROUTE_NONE    = 2'd0;
  localparam logic [1:0] ROUTE_BCAST   = 2'd1;
  localparam logic [1:0] ROUTE_UNICAST = 2'd2;

  localparam int unsigned KEY_W    = 44;
  localparam int unsigned CLIENT_W = 32;
  localparam int unsigned HELD_W   = 5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] src_client;
    logic [31:0] device_uid;
    logic [7:0]  function_id;
    logic [3:0]  sequence_number;
    logic        rsp_wanted;
  } req_t;

  typedef struct packed {
    logic [1:0]        route;
    logic [31:0]       target_client;
    logic              evicted_oldest;
    logic [HELD_W-1:0] entries_held;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [CLIENT_W-1:0] client;
  } entry_t;

  typedef struct packed {
    logic quick;
    logic scan_begin;
    logic scan_run;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_done;
  } status_t;

endpackage

[src/rrt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/rrt_ctrl.sv]
// Controller state machine for the response route table.
`timescale 1ns / 1ps

module rrt_ctrl import rrt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0] state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.quick      = !status_i.needs_scan;
          cmd_o.scan_begin = status_i.needs_scan;
          if (status_i.needs_scan) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.scan_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == ST_SCAN);

`ifndef SYNTHESIS
  a_finish_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !busy_o)
    else $error("controller still busy after finishing a scan");
`endif

endmodule

[src/rrt_datapath.sv]
// Datapath: age-ordered entry store, compaction scan and result register.
`timescale 1ns / 1ps

module rrt_datapath import rrt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    req_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output logic    done_o,
  output rsp_t    rsp_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // Map an age index onto a RAM slot of the circular store.
  function automatic logic [AW-1:0] phys_addr(logic [CW-1:0] idx, logic [AW-1:0] head);
    logic [CW:0] sum;
    sum = {1'b0, idx} + (CW+1)'(head);
    if (sum >= (CW+1)'(TABLE_DEPTH)) begin
      sum = sum - (CW+1)'(TABLE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [AW-1:0]    head_q;
  logic [CW-1:0]    count_q, rd_idx_q, wr_idx_q;
  logic             rv_q, found_q, done_q;
  logic [1:0]       type_q;
  logic [CLIENT_W-1:0] client_q, target_q;
  logic [KEY_W-1:0] key_q;
  rsp_t             rsp_q;

  logic [KEY_W-1:0] key_in;
  logic             keep_rec, full, drop, keep_wr, issue_rd;
  logic [AW:0]      head_inc;
  logic [AW-1:0]    head_next;
  entry_t           rd_entry, wr_entry;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [CW-1:0]    count_rec;

  assign key_in   = {req_i.device_uid, req_i.function_id, req_i.sequence_number};
  assign keep_rec = (req_i.req_type == REQ_RECORD) && (req_i.device_uid != '0)
                    && req_i.rsp_wanted;
  assign full     = (count_q == CW'(TABLE_DEPTH));
  assign head_inc = {1'b0, head_q} + (AW+1)'(1);
  assign head_next = (head_inc == (AW+1)'(TABLE_DEPTH)) ? '0 : head_inc[AW-1:0];
  assign count_rec = (keep_rec && !full) ? count_q + CW'(1) : count_q;

  assign status_o.needs_scan = ((req_i.req_type == REQ_ROUTE) && (req_i.sequence_number != '0))
                               || (req_i.req_type == REQ_DISCONNECT);
  assign status_o.scan_done  = (rd_idx_q == count_q) && !rv_q;

  // Disconnect drops every entry of the client; a response drops the first match only.
  assign drop     = (type_q == REQ_DISCONNECT) ? (rd_entry.client == client_q)
                                               : (!found_q && (rd_entry.key == key_q));
  assign keep_wr  = cmd_i.scan_run && rv_q && !drop;
  assign issue_rd = cmd_i.scan_run && (rd_idx_q < count_q);

  // A full table overwrites the oldest slot, which is where the new tail lands.
  assign ram_we    = (cmd_i.quick && keep_rec) || keep_wr;
  assign ram_waddr = cmd_i.scan_run ? phys_addr(wr_idx_q, head_q) : phys_addr(count_q, head_q);
  assign ram_raddr = phys_addr(rd_idx_q, head_q);
  assign wr_entry  = cmd_i.scan_run ? rd_entry
                                    : entry_t'{key: key_in, client: req_i.src_client};

  rrt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      rv_q     <= 1'b0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.quick || cmd_i.finish;
      if (cmd_i.quick) begin
        if (keep_rec && full) begin
          head_q <= head_next;
        end
        count_q <= count_rec;
      end else if (cmd_i.scan_begin) begin
        rd_idx_q <= '0;
        wr_idx_q <= '0;
        rv_q     <= 1'b0;
        found_q  <= 1'b0;
      end else if (cmd_i.scan_run) begin
        rv_q <= issue_rd;
        if (issue_rd) begin
          rd_idx_q <= rd_idx_q + CW'(1);
        end
        if (rv_q && drop) begin
          found_q <= 1'b1;
        end
        if (keep_wr) begin
          wr_idx_q <= wr_idx_q + CW'(1);
        end
        if (cmd_i.finish) begin
          count_q <= wr_idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.quick || cmd_i.scan_begin) begin
      type_q   <= req_i.req_type;
      client_q <= req_i.src_client;
      key_q    <= key_in;
    end
    if (cmd_i.scan_run && rv_q && drop && !found_q) begin
      target_q <= rd_entry.client;
    end
    if (cmd_i.quick) begin
      rsp_q.route          <= (req_i.req_type == REQ_ROUTE) ? ROUTE_BCAST : ROUTE_NONE;
      rsp_q.target_client  <= '0;
      rsp_q.evicted_oldest <= keep_rec && full;
      rsp_q.entries_held   <= HELD_W'(count_rec);
    end else if (cmd_i.finish) begin
      rsp_q.evicted_oldest <= 1'b0;
      rsp_q.entries_held   <= HELD_W'(wr_idx_q);
      if (type_q == REQ_ROUTE && found_q) begin
        rsp_q.route         <= ROUTE_UNICAST;
        rsp_q.target_client <= target_q;
      end else begin
        rsp_q.route         <= (type_q == REQ_ROUTE) ? ROUTE_BCAST : ROUTE_NONE;
        rsp_q.target_client <= '0;
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_wr_behind_rd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_idx_q <= rd_idx_q)
    else $error("compaction write index overtook read index");
  a_done_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd_i.quick || cmd_i.finish))
    else $error("result strobe without a completed item");
`endif

endmodule

[src/response_route_table.sv]
// Top level of the response route table.
`timescale 1ns / 1ps

// Remembers which client sent each request so that its response can be routed back.
// Input: drive req_i and raise start; the transfer happens at the clock edge where
// start is high and busy is low. Output: done_o is high for exactly one cycle with
// rsp_o valid; the receiver takes it in that cycle and cannot hold it off.
// Records, callbacks (sequence zero) and unknown types finish at once: the result
// shows the cycle after the transfer and busy stays low, so one item per cycle.
// Routed responses and disconnects scan the open entries through the single RAM
// read port, compacting the table in place: busy is high while the scan runs,
// and the result shows in the cycle busy falls. The rate of these items is set by
// that one-entry-per-cycle scan: no new item is taken until its result shows.
// Reset empties the table through its entry count; the RAM itself is not cleared
// and no clearing pass runs.
module response_route_table import rrt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  cmd_t    cmd;
  status_t status;

  rrt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  rrt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .done_o   (done_o),
    .rsp_o    (rsp_o)
  );

endmodule
